@@ design/key_event_engine_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Key event engine assertion macros
// Shared concurrent assertion forms used by the key event engine RTL.
// ----------------------------------------------------------------------------
`ifndef KEY_EVENT_ENGINE_UNIT_DEFINES_SVH
`define KEY_EVENT_ENGINE_UNIT_DEFINES_SVH

// Condition must hold at every clock edge outside reset
`define KEU_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) 1'b1 |-> (cond)) else $error(msg);

// Same-cycle implication
`define KEU_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define KEU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/keu_pkg.sv @@
// ----------------------------------------------------------------------------
// Key event engine package
// Widths, key bit maps, reset values and shared types of the key engine.
// ----------------------------------------------------------------------------
package keu_pkg;

   // Key vector and timer widths
   localparam int KEY_W      = 15;
   localparam int KEY_IDX_W  = 4;
   localparam int NUM_LONG   = 7;
   localparam int NUM_ARROW  = 4;
   localparam int HOLD_W     = 13;
   localparam int ARROW_T_W  = 12;
   localparam int POLLS_W    = 2;
   localparam int GUARD_W    = 6;

   // Debounce and startup guard
   localparam logic [POLLS_W-1:0] DEBOUNCE_POLLS = 2'd2;
   localparam logic [GUARD_W-1:0] GUARD_POLLS    = 6'd50;

   // Keys blocked by the startup guard, keys with short/long behavior
   localparam logic [KEY_W-1:0] GUARD_SET = 15'h201F;
   localparam logic [KEY_W-1:0] LONG_SET  = 15'h281F;

   // Arrow hold timer saturation point
   localparam logic [ARROW_T_W-1:0] HOLD_CAP_MS = 12'd2000;

   // Lane to key bit maps: move f2 f3 f4 auto save ch1 / left right up down
   localparam logic [KEY_IDX_W-1:0] LONG_BIT [NUM_LONG] =
      '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd13, 4'd11};
   localparam logic [KEY_IDX_W-1:0] ARROW_BIT [NUM_ARROW] =
      '{4'd6, 4'd7, 4'd8, 4'd9};

   // Control/status port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 15;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ACTIVE_HIGH_MASK   = 3'd0,
      CSR_POLL_PERIOD        = 3'd1,
      CSR_LONG_PRESS         = 3'd2,
      CSR_REPEAT_START       = 3'd3,
      CSR_REPEAT_FAST        = 3'd4,
      CSR_REPEAT_SLOW_INTVL  = 3'd5,
      CSR_REPEAT_FAST_INTVL  = 3'd6
   } csr_index_type;

   // Register reset values
   localparam logic [KEY_W-1:0] RST_ACTIVE_HIGH_MASK = 15'd8;
   localparam logic [7:0]       RST_POLL_PERIOD      = 8'd20;
   localparam logic [11:0]      RST_LONG_PRESS       = 12'd700;
   localparam logic [10:0]      RST_REPEAT_START     = 11'd360;
   localparam logic [10:0]      RST_REPEAT_FAST      = 11'd900;
   localparam logic [10:0]      RST_SLOW_INTVL       = 11'd120;
   localparam logic [10:0]      RST_FAST_INTVL       = 11'd40;

   // Timing settings seen by the lanes
   typedef struct packed {
      logic [7:0]  poll_ms;
      logic [11:0] long_ms;
      logic [10:0] rep_start_ms;
      logic [10:0] rep_fast_ms;
      logic [10:0] slow_int_ms;
      logic [10:0] fast_int_ms;
   } timing_cfg_type;

   // Per-lane tick control
   typedef struct packed {
      logic step;
      logic now_key;
      logic last_key;
   } lane_ctl_type;

   // Long-capable lane events
   typedef struct packed {
      logic short_ev;
      logic long_ev;
   } long_evt_type;

   // Result payload, press events in the low bits
   typedef struct packed {
      logic [KEY_W-1:0]    debounced_keys;
      logic                repeat_flag;
      logic [NUM_LONG-1:0] long_events;
      logic [KEY_W-1:0]    press_events;
   } rsp_type;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 40;
   localparam int RSP_PAD_W  = RSP_DATA_W - $bits(rsp_type);

endpackage

@@ design/keu_long_lane.sv @@
// ----------------------------------------------------------------------------
// Key event engine long-press lane
// Hold timer for one short/long key: short event on release, long on hold.
// ----------------------------------------------------------------------------
module keu_long_lane (
   input  logic                   clock,
   input  logic                   reset,
   input  keu_pkg::timing_cfg_type cfg,
   input  keu_pkg::lane_ctl_type   ctl,
   output keu_pkg::long_evt_type   evt
);
   import keu_pkg::*;

   logic [HOLD_W-1:0] hold_ff, hold_in;
   logic              fired_ff, fired_in;
   logic [HOLD_W-1:0] long_ms_ext;
   logic [HOLD_W-1:0] hold_adv;

   // Timer advances only while below the long press threshold
   always_comb begin
      long_ms_ext = {1'b0, cfg.long_ms};
      hold_adv    = (hold_ff < long_ms_ext) ? hold_ff + HOLD_W'(cfg.poll_ms) : hold_ff;
   end

   // Per-tick update
   always_comb begin
      hold_in  = hold_ff;
      fired_in = fired_ff;
      evt      = '0;
      if (ctl.step) begin
         if (ctl.now_key) begin
            if (!ctl.last_key) begin
               hold_in  = '0;
               fired_in = 1'b0;
            end else if (!fired_ff) begin
               hold_in = hold_adv;
               if (hold_adv >= long_ms_ext) begin
                  fired_in    = 1'b1;
                  evt.long_ev = 1'b1;
               end
            end
         end else begin
            evt.short_ev = ctl.last_key & ~fired_ff;
            hold_in      = '0;
            fired_in     = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff  <= '0;
         fired_ff <= 1'b0;
      end else begin
         hold_ff  <= hold_in;
         fired_ff <= fired_in;
      end
   end

endmodule

@@ design/keu_arrow_lane.sv @@
// ----------------------------------------------------------------------------
// Key event engine arrow lane
// Auto-repeat for one arrow key: slow interval, then fast after a hold time.
// ----------------------------------------------------------------------------
module keu_arrow_lane (
   input  logic                    clock,
   input  logic                    reset,
   input  keu_pkg::timing_cfg_type cfg,
   input  keu_pkg::lane_ctl_type   ctl,
   output logic                    fire
);
   import keu_pkg::*;

   logic [ARROW_T_W-1:0] hold_ff, hold_in;
   logic [ARROW_T_W-1:0] rep_ff, rep_in;
   logic [ARROW_T_W-1:0] hold_adv;
   logic [ARROW_T_W-1:0] rep_sum;
   logic [10:0]          interval;

   // Hold timer saturates at the cap, repeat timer accumulates once the repeat start is reached
   always_comb begin
      hold_adv = (hold_ff < HOLD_CAP_MS) ? hold_ff + ARROW_T_W'(cfg.poll_ms) : hold_ff;
      rep_sum  = rep_ff + ARROW_T_W'(cfg.poll_ms);
      interval = (hold_adv >= {1'b0, cfg.rep_fast_ms}) ? cfg.fast_int_ms : cfg.slow_int_ms;
   end

   // Per-tick update
   always_comb begin
      hold_in = hold_ff;
      rep_in  = rep_ff;
      fire    = 1'b0;
      if (ctl.step) begin
         if (!(ctl.now_key && ctl.last_key)) begin
            hold_in = '0;
            rep_in  = '0;
         end else begin
            hold_in = hold_adv;
            if (hold_adv >= {1'b0, cfg.rep_start_ms}) begin
               if (rep_sum >= {1'b0, interval}) begin
                  rep_in = '0;
                  fire   = 1'b1;
               end else begin
                  rep_in = rep_sum;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= '0;
         rep_ff  <= '0;
      end else begin
         hold_ff <= hold_in;
         rep_ff  <= rep_in;
      end
   end

endmodule

@@ design/key_event_engine_unit.sv @@
// ----------------------------------------------------------------------------
// Key event engine
// Keypad debounce, startup guard, short/long press and arrow auto-repeat.
//
//   Channel  Direction  Item
//   req_     in         pin_levels, one poll tick per transfer
//   rsp_     out        press/long events, repeat flag, debounced keys
//   csr_     in         timing and polarity register writes
//
// One poll tick per clock cycle while req_tready is high; the result is registered.
// Seven long-press lanes and four arrow lanes update in parallel, then merge.
// A two-entry output buffer keeps req_tready high through one stalled result.
// Synchronous reset restores register defaults and the 50-tick startup guard.
// ----------------------------------------------------------------------------
`include "key_event_engine_unit_defines.svh"

module key_event_engine_unit (
   input  logic                             clock,
   input  logic                             reset,
   // req_tdata: [14:0] pin_levels
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [keu_pkg::REQ_DATA_W-1:0]   req_tdata,
   // rsp_tdata: [14:0] press_events, [21:15] long_events, [22] repeat_flag,
   //            [37:23] debounced_keys
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [keu_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                             csr_we,
   input  logic [keu_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [keu_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import keu_pkg::*;

   // Registers
   logic [KEY_W-1:0]   mask_ff;
   timing_cfg_type     cfg_ff;
   logic [KEY_W-1:0]   cand_ff, cand_in;
   logic [KEY_W-1:0]   stable_ff, stable_in;
   logic [POLLS_W-1:0] polls_ff, polls_in;
   logic               seen_ff, seen_in;
   logic [GUARD_W-1:0] guard_ff, guard_in;
   logic [KEY_W-1:0]   prev_ff, prev_in;
   logic [KEY_W-1:0]   blocked_ff, blocked_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;
   logic               skid_valid_ff, skid_valid_in;
   rsp_type            skid_data_ff, skid_data_in;

   logic               acc;
   logic               out_take;
   logic               normal;
   logic [KEY_W-1:0]   raw;
   logic [KEY_W-1:0]   blk_norm;
   logic [KEY_W-1:0]   now_m;
   logic [KEY_W-1:0]   last_m;
   rsp_type            rsp_new;

   lane_ctl_type       long_ctl  [NUM_LONG];
   long_evt_type       long_evt  [NUM_LONG];
   lane_ctl_type       arrow_ctl [NUM_ARROW];
   logic               arrow_fire[NUM_ARROW];

   assign acc        = req_tvalid & req_tready;
   assign out_take   = rsp_valid_ff & rsp_tready;
   assign req_tready = ~skid_valid_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_data_ff};

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff            <= RST_ACTIVE_HIGH_MASK;
         cfg_ff.poll_ms     <= RST_POLL_PERIOD;
         cfg_ff.long_ms     <= RST_LONG_PRESS;
         cfg_ff.rep_start_ms <= RST_REPEAT_START;
         cfg_ff.rep_fast_ms <= RST_REPEAT_FAST;
         cfg_ff.slow_int_ms <= RST_SLOW_INTVL;
         cfg_ff.fast_int_ms <= RST_FAST_INTVL;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_ACTIVE_HIGH_MASK:  mask_ff             <= csr_wdata;
            CSR_POLL_PERIOD:       cfg_ff.poll_ms      <= csr_wdata[7:0];
            CSR_LONG_PRESS:        cfg_ff.long_ms      <= csr_wdata[11:0];
            CSR_REPEAT_START:      cfg_ff.rep_start_ms <= csr_wdata[10:0];
            CSR_REPEAT_FAST:       cfg_ff.rep_fast_ms  <= csr_wdata[10:0];
            CSR_REPEAT_SLOW_INTVL: cfg_ff.slow_int_ms  <= csr_wdata[10:0];
            CSR_REPEAT_FAST_INTVL: cfg_ff.fast_int_ms  <= csr_wdata[10:0];
            default: ;
         endcase
      end
   end

   // Polarity and debounce
   always_comb begin
      raw = ~(req_tdata[KEY_W-1:0] ^ mask_ff);
      if (raw == cand_ff) begin
         cand_in  = cand_ff;
         polls_in = (polls_ff < DEBOUNCE_POLLS) ? polls_ff + 2'd1 : polls_ff;
      end else begin
         cand_in  = raw;
         polls_in = '0;
      end
      stable_in = (polls_in >= DEBOUNCE_POLLS) ? cand_in : stable_ff;
   end

   // Startup phases and key blocking
   always_comb begin
      normal   = seen_ff && (guard_ff == '0);
      blk_norm = blocked_ff & stable_in;
      now_m    = stable_in & ~blk_norm;
      last_m   = prev_ff & ~blk_norm;
      seen_in    = 1'b1;
      guard_in   = guard_ff;
      blocked_in = blocked_ff;
      prev_in    = stable_in;
      if (!seen_ff) begin
         blocked_in = '0;
      end else if (guard_ff != '0) begin
         guard_in   = guard_ff - 6'd1;
         blocked_in = blocked_ff | (stable_in & GUARD_SET);
      end else begin
         blocked_in = blk_norm;
         prev_in    = now_m;
      end
   end

   // Long-capable key lanes
   for (genvar g = 0; g < NUM_LONG; g++) begin : g_long
      assign long_ctl[g] = '{step:     acc & normal,
                             now_key:  now_m[LONG_BIT[g]],
                             last_key: last_m[LONG_BIT[g]]};
      keu_long_lane u_lane (
         .clock (clock),
         .reset (reset),
         .cfg   (cfg_ff),
         .ctl   (long_ctl[g]),
         .evt   (long_evt[g])
      );
   end

   // Arrow key lanes
   for (genvar g = 0; g < NUM_ARROW; g++) begin : g_arrow
      assign arrow_ctl[g] = '{step:     acc & normal,
                              now_key:  now_m[ARROW_BIT[g]],
                              last_key: last_m[ARROW_BIT[g]]};
      keu_arrow_lane u_lane (
         .clock (clock),
         .reset (reset),
         .cfg   (cfg_ff),
         .ctl   (arrow_ctl[g]),
         .fire  (arrow_fire[g])
      );
   end

   // Merge lane results into one result
   always_comb begin
      rsp_new = '0;
      rsp_new.debounced_keys = stable_in;
      if (normal) begin
         rsp_new.press_events = now_m & ~last_m & ~LONG_SET;
      end
      for (int i = 0; i < NUM_LONG; i++) begin
         rsp_new.press_events[LONG_BIT[i]] =
            rsp_new.press_events[LONG_BIT[i]] | long_evt[i].short_ev;
         rsp_new.long_events[i] = long_evt[i].long_ev;
      end
      for (int i = 0; i < NUM_ARROW; i++) begin
         rsp_new.press_events[ARROW_BIT[i]] =
            rsp_new.press_events[ARROW_BIT[i]] | arrow_fire[i];
         rsp_new.repeat_flag = rsp_new.repeat_flag | arrow_fire[i];
      end
   end

   // Output register plus skid entry
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (acc) begin
         if (!rsp_valid_ff || out_take) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = rsp_new;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = rsp_new;
         end
      end else if (out_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cand_ff       <= '0;
         stable_ff     <= '0;
         polls_ff      <= '0;
         seen_ff       <= 1'b0;
         guard_ff      <= GUARD_POLLS;
         prev_ff       <= '0;
         blocked_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (acc) begin
            cand_ff    <= cand_in;
            stable_ff  <= stable_in;
            polls_ff   <= polls_in;
            seen_ff    <= seen_in;
            guard_ff   <= guard_in;
            prev_ff    <= prev_in;
            blocked_ff <= blocked_in;
         end
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   // Checks
   `KEU_ASSERT_ALWAYS(a_blocked_guarded, clock, reset, (blocked_ff & ~GUARD_SET) == '0, "non-guarded key blocked")
   `KEU_ASSERT_ALWAYS(a_polls_range, clock, reset, polls_ff <= DEBOUNCE_POLLS, "debounce count overrun")
   `KEU_ASSERT_IMPL(a_skid_order, clock, reset, skid_valid_ff, rsp_valid_ff, "skid entry without output entry")
   `KEU_ASSERT_IMPL(a_guard_idle, clock, reset, !seen_ff, guard_ff == GUARD_POLLS, "guard ran before first tick")
   `KEU_ASSERT_NEXT(a_first_tick, clock, reset, acc && !seen_ff, seen_ff && (blocked_ff == '0), "first tick did not clear blocking")

endmodule

@@ dv/key_event_engine_unit_checker.sv @@
// ----------------------------------------------------------------------------
// Key event engine checker
// Watches the request, result and register ports of the key event engine,
// keeps its own model of debounce, startup guard, long press and arrow
// repeat, and compares every result transfer field by field in order.
// ----------------------------------------------------------------------------
module key_event_engine_unit_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [keu_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [keu_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           csr_we,
   input  logic [keu_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [keu_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                             mismatches,
   output int                             outstanding,
   output int                             results_seen,
   output int                             long_seen,
   output int                             repeat_seen
);
   import keu_pkg::*;

   // Cap on printed mismatch lines; counting goes on past it
   localparam int MAX_REPORTS = 40;

   // Register copies
   logic [KEY_W-1:0] pin_polarity;
   logic [7:0]       tick_ms;
   logic [11:0]      long_thresh_ms;
   logic [10:0]      rpt_start_ms;
   logic [10:0]      rpt_fast_ms;
   logic [10:0]      rpt_slow_gap;
   logic [10:0]      rpt_fast_gap;

   // Debounce and guard state
   logic [KEY_W-1:0]   cand_keys;
   logic [KEY_W-1:0]   settled_keys;
   logic [POLLS_W-1:0] settle_polls;
   logic               first_done;
   logic [GUARD_W-1:0] guard_ticks;
   logic [KEY_W-1:0]   prior_keys;
   logic [KEY_W-1:0]   locked_keys;

   // Per-lane hold timers
   logic [HOLD_W-1:0]    lane_hold_ms [NUM_LONG];
   logic                 lane_done    [NUM_LONG];
   logic [ARROW_T_W-1:0] arrow_held_ms  [NUM_ARROW];
   logic [ARROW_T_W-1:0] arrow_since_ms [NUM_ARROW];

   // Results predicted but not yet seen, oldest first
   rsp_type tick_results [$];

   // One poll tick: update the key state, return the result it gives
   function automatic rsp_type poll_tick(input logic [KEY_W-1:0] pins);
      rsp_type             res;
      logic [KEY_W-1:0]    raw;
      logic [KEY_W-1:0]    now_k;
      logic [KEY_W-1:0]    prev_k;
      logic [KEY_W-1:0]    press;
      logic [NUM_LONG-1:0] longs;
      logic [10:0]         gap;
      logic                rep;
      int                  i;
      int                  b;
      raw    = ~(pins ^ pin_polarity);
      press  = '0;
      longs  = '0;
      rep    = 1'b0;
      prev_k = '0;

      // debounce: a pattern must repeat on two further polls
      if (raw == cand_keys) begin
         if (settle_polls < DEBOUNCE_POLLS) settle_polls = settle_polls + 2'd1;
      end else begin
         cand_keys    = raw;
         settle_polls = '0;
      end
      if (settle_polls >= DEBOUNCE_POLLS) settled_keys = cand_keys;
      now_k = settled_keys;

      if (!first_done) begin
         first_done  = 1'b1;
         locked_keys = '0;
         prior_keys  = now_k;
      end else if (guard_ticks != '0) begin
         // startup guard: silent, remember guarded keys held now
         guard_ticks = guard_ticks - 1'b1;
         locked_keys = locked_keys | (now_k & GUARD_SET);
         prior_keys  = now_k;
      end else begin
         locked_keys = locked_keys & now_k;
         now_k  = now_k & ~locked_keys;
         prev_k = prior_keys & ~locked_keys;
         press  = now_k & ~prev_k & ~LONG_SET;

         // short/long lanes
         for (i = 0; i < NUM_LONG; i++) begin
            b = LONG_BIT[i];
            if (now_k[b]) begin
               if (!prev_k[b]) begin
                  lane_hold_ms[i] = '0;
                  lane_done[i]    = 1'b0;
               end else if (!lane_done[i]) begin
                  if (lane_hold_ms[i] < long_thresh_ms)
                     lane_hold_ms[i] = lane_hold_ms[i] + tick_ms;
                  if (lane_hold_ms[i] >= long_thresh_ms) begin
                     lane_done[i] = 1'b1;
                     longs[i]     = 1'b1;
                  end
               end
            end else begin
               if (prev_k[b] && !lane_done[i]) press[b] = 1'b1;
               lane_hold_ms[i] = '0;
               lane_done[i]    = 1'b0;
            end
         end

         // arrow lanes: hold timer saturates, slow then fast repeat
         for (i = 0; i < NUM_ARROW; i++) begin
            b = ARROW_BIT[i];
            if (!now_k[b] || !prev_k[b]) begin
               arrow_held_ms[i]  = '0;
               arrow_since_ms[i] = '0;
            end else begin
               if (arrow_held_ms[i] < HOLD_CAP_MS)
                  arrow_held_ms[i] = arrow_held_ms[i] + tick_ms;
               if (arrow_held_ms[i] >= rpt_start_ms) begin
                  gap = (arrow_held_ms[i] >= rpt_fast_ms) ? rpt_fast_gap : rpt_slow_gap;
                  arrow_since_ms[i] = arrow_since_ms[i] + tick_ms;
                  if (arrow_since_ms[i] >= gap) begin
                     arrow_since_ms[i] = '0;
                     press[b] = 1'b1;
                     rep      = 1'b1;
                  end
               end
            end
         end

         prior_keys = now_k;
      end

      res.press_events   = press;
      res.long_events    = longs;
      res.repeat_flag    = rep;
      res.debounced_keys = settled_keys;
      return res;
   endfunction

   task automatic check_field(input string label, input logic [KEY_W:0] want,
                              input logic [KEY_W:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, label, want, got);
      end
   endtask

   // Track registers, requests and results at each rising edge
   always @(posedge clock) begin : track
      rsp_type seen;
      rsp_type want;
      if (reset) begin
         pin_polarity   = RST_ACTIVE_HIGH_MASK;
         tick_ms        = RST_POLL_PERIOD;
         long_thresh_ms = RST_LONG_PRESS;
         rpt_start_ms   = RST_REPEAT_START;
         rpt_fast_ms    = RST_REPEAT_FAST;
         rpt_slow_gap   = RST_SLOW_INTVL;
         rpt_fast_gap   = RST_FAST_INTVL;
         cand_keys      = '0;
         settled_keys   = '0;
         settle_polls   = '0;
         first_done     = 1'b0;
         guard_ticks    = GUARD_POLLS;
         prior_keys     = '0;
         locked_keys    = '0;
         for (int i = 0; i < NUM_LONG; i++) begin
            lane_hold_ms[i] = '0;
            lane_done[i]    = 1'b0;
         end
         for (int i = 0; i < NUM_ARROW; i++) begin
            arrow_held_ms[i]  = '0;
            arrow_since_ms[i] = '0;
         end
         tick_results.delete();
         mismatches   = 0;
         results_seen = 0;
         long_seen    = 0;
         repeat_seen  = 0;
      end else begin
         // register writes, masked to register width
         if (csr_we) begin
            case (csr_index)
               CSR_ACTIVE_HIGH_MASK:  pin_polarity   = csr_wdata;
               CSR_POLL_PERIOD:       tick_ms        = csr_wdata[7:0];
               CSR_LONG_PRESS:        long_thresh_ms = csr_wdata[11:0];
               CSR_REPEAT_START:      rpt_start_ms   = csr_wdata[10:0];
               CSR_REPEAT_FAST:       rpt_fast_ms    = csr_wdata[10:0];
               CSR_REPEAT_SLOW_INTVL: rpt_slow_gap   = csr_wdata[10:0];
               CSR_REPEAT_FAST_INTVL: rpt_fast_gap   = csr_wdata[10:0];
               default: ;
            endcase
         end

         if (req_tvalid && req_tready)
            tick_results.push_back(poll_tick(req_tdata[KEY_W-1:0]));

         // result transfer: compare against the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            seen = rsp_tdata[$bits(rsp_type)-1:0];
            results_seen++;
            if (seen.long_events != '0) long_seen++;
            if (seen.repeat_flag) repeat_seen++;
            if (tick_results.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("%0t: result with none expected, expected nothing, actual 0x%0h",
                           $time, rsp_tdata);
            end else begin
               want = tick_results.pop_front();
               check_field("press_events", want.press_events, seen.press_events);
               check_field("long_events", want.long_events, seen.long_events);
               check_field("repeat_flag", want.repeat_flag, seen.repeat_flag);
               check_field("debounced_keys", want.debounced_keys, seen.debounced_keys);
               check_field("tdata padding", '0, rsp_tdata[RSP_DATA_W-1 -: RSP_PAD_W]);
            end
         end
      end
      outstanding = tick_results.size();
   end

endmodule

@@ dv/key_event_engine_unit_test.sv @@
// ----------------------------------------------------------------------------
// Key event engine testbench
// Drives poll ticks built from key hold scenarios (presses, long holds,
// arrow holds, bounces and raw pin noise) through several register
// settings and idle profiles; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module key_event_engine_unit_test;
   import keu_pkg::*;

   localparam int CYCLE_LIMIT     = 200000;
   localparam int HOLD_OFF_CYCLES = 60;
   localparam int MAX_SPAN        = 150;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 3'd7;
   localparam logic [KEY_W-1:0] ARROW_KEYS = 15'h03C0;
   localparam logic [KEY_W-1:0] CORNER_PINS [4] = '{15'h0000, 15'h7FFF, 15'h5555, 15'h2AAA};

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int mismatches;
   int outstanding;
   int results_seen;
   int long_seen;
   int repeat_seen;

   int send_idle_pct = 28;
   int recv_idle_pct = 68;
   bit rsp_hold_off  = 1'b0;
   int ticks_sent    = 0;
   int cycle_count   = 0;

   // Register mirror used to build pin levels and hold lengths
   logic [KEY_W-1:0] pin_polarity;
   timing_cfg_type   cfg;

   key_event_engine_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   key_event_engine_unit_checker checker_i (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .mismatches   (mismatches),
      .outstanding  (outstanding),
      .results_seen (results_seen),
      .long_seen    (long_seen),
      .repeat_seen  (repeat_seen)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // Run limit
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, outstanding);
      $display("key_event_engine_unit_test failed");
      $finish;
   end

   // Result side: random ready, or a long hold-off when asked
   initial begin
      rsp_tready <= 1'b0;
      @(posedge clock);
      forever begin
         if (rsp_hold_off) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            rsp_hold_off = 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
            @(posedge clock);
         end
      end
   end

   // One poll tick transfer, with random idle cycles ahead of it
   task automatic send_pins(input logic [KEY_W-1:0] pins);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W-KEY_W){1'b0}}, pins};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      ticks_sent++;
   endtask

   // Hold a pressed-key pattern for some ticks, with rare one-tick glitches
   task automatic hold_keys(input logic [KEY_W-1:0] pressed, input int ticks);
      logic [KEY_W-1:0] pins;
      int               idx;
      for (int n = 0; n < ticks; n++) begin
         pins = ~(pressed ^ pin_polarity);
         if ($urandom_range(99) < 3) begin
            idx = $urandom_range(KEY_W-1);
            pins[idx] = ~pins[idx];
         end
         send_pins(pins);
      end
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_ACTIVE_HIGH_MASK:  pin_polarity     = val;
         CSR_POLL_PERIOD:       cfg.poll_ms      = val[7:0];
         CSR_LONG_PRESS:        cfg.long_ms      = val[11:0];
         CSR_REPEAT_START:      cfg.rep_start_ms = val[10:0];
         CSR_REPEAT_FAST:       cfg.rep_fast_ms  = val[10:0];
         CSR_REPEAT_SLOW_INTVL: cfg.slow_int_ms  = val[10:0];
         CSR_REPEAT_FAST_INTVL: cfg.fast_int_ms  = val[10:0];
         default: ;
      endcase
   endtask

   // Write every register, plus the unused index, which must be ignored
   task automatic apply_settings(input logic [CSR_DATA_W-1:0] mask, poll, long_press,
                                 start, fast, slow_gap, fast_gap);
      write_reg(CSR_ACTIVE_HIGH_MASK, mask);
      write_reg(CSR_POLL_PERIOD, poll);
      write_reg(CSR_LONG_PRESS, long_press);
      write_reg(CSR_REPEAT_START, start);
      write_reg(CSR_REPEAT_FAST, fast);
      write_reg(CSR_REPEAT_SLOW_INTVL, slow_gap);
      write_reg(CSR_REPEAT_FAST_INTVL, fast_gap);
      write_reg(CSR_SPARE, 15'($urandom_range(32767)));
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Stop offering and wait for every predicted result
   task automatic drain();
      req_tvalid <= 1'b0;
      // let the checker record the last transfer before looking at the count
      @(posedge clock);
      wait (outstanding == 0);
      repeat (4) @(posedge clock);
   endtask

   // Ticks needed to reach long press and a few arrow repeats
   function automatic int hold_span();
      int poll;
      int long_ticks;
      int arrow_ticks;
      int span;
      poll        = (cfg.poll_ms == 0) ? 1 : cfg.poll_ms;
      long_ticks  = cfg.long_ms / poll + 3;
      arrow_ticks = ((cfg.rep_start_ms > cfg.rep_fast_ms) ? cfg.rep_start_ms : cfg.rep_fast_ms);
      arrow_ticks = (arrow_ticks + 3 * cfg.slow_int_ms) / poll + 3;
      span = (long_ticks > arrow_ticks) ? long_ticks : arrow_ticks;
      return (span > MAX_SPAN) ? MAX_SPAN : span;
   endfunction

   // Random scenarios: mostly clean holds, some bounces and pin noise
   task automatic run_random(input int n_ticks);
      int               stop_at;
      int               kind;
      int               span;
      logic [KEY_W-1:0] keys;
      stop_at = ticks_sent + n_ticks;
      while (ticks_sent < stop_at) begin
         kind = $urandom_range(99);
         span = hold_span();
         keys = '0;
         if (kind < 55) begin
            // press and hold a key or a chord, then release
            if ($urandom_range(3) == 0) keys = 15'($urandom_range(32767));
            else keys[$urandom_range(KEY_W-1)] = 1'b1;
            hold_keys(keys, $urandom_range(span, 1));
            hold_keys('0, $urandom_range(6, 3));
         end else if (kind < 75) begin
            // arrow hold aimed at fast repeat, unless the MAX_SPAN cap cuts it short
            keys = ARROW_KEYS & 15'($urandom_range(32767));
            keys[ARROW_BIT[$urandom_range(NUM_ARROW-1)]] = 1'b1;
            if ($urandom_range(3) == 0) keys = keys | 15'($urandom_range(32767));
            hold_keys(keys, span + $urandom_range(20));
            hold_keys('0, $urandom_range(6, 3));
         end else if (kind < 88) begin
            // raw pin noise
            repeat ($urandom_range(8, 1)) send_pins(15'($urandom_range(32767)));
         end else begin
            // bounce too short to debounce
            keys = 15'($urandom_range(32767));
            hold_keys(keys, $urandom_range(2, 1));
            hold_keys('0, 3);
         end
      end
   endtask

   // Stimulus and verdict
   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_we     <= 1'b0;
      csr_index  <= CSR_ACTIVE_HIGH_MASK;
      csr_wdata  <= '0;
      pin_polarity     = RST_ACTIVE_HIGH_MASK;
      cfg.poll_ms      = RST_POLL_PERIOD;
      cfg.long_ms      = RST_LONG_PRESS;
      cfg.rep_start_ms = RST_REPEAT_START;
      cfg.rep_fast_ms  = RST_REPEAT_FAST;
      cfg.slow_int_ms  = RST_SLOW_INTVL;
      cfg.fast_int_ms  = RST_FAST_INTVL;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: pin extremes, first tick, all keys and no keys
      for (int c = 0; c < 4; c++) repeat (3) send_pins(CORNER_PINS[c]);
      repeat (3) send_pins(~(15'h7FFF ^ pin_polarity));
      repeat (3) send_pins(~(15'h0000 ^ pin_polarity));

      // Guarded keys, ch1 and an arrow held across the end of the guard
      hold_keys(GUARD_SET | (15'h1 << LONG_BIT[6]) | (15'h1 << ARROW_BIT[0]), 45);
      hold_keys('0, 5);

      // Reset settings, slow receiver
      run_random(480);
      drain();

      // Timing registers at their low end, all keys active high, slow sender
      send_idle_pct = 68;
      recv_idle_pct = 28;
      apply_settings(15'h7FFF, 15'd1, 15'd0, 15'd0, 15'd0, 15'd1, 15'd1);
      run_random(300);
      drain();

      // High end, poll written with spare upper bits set; no idling from here
      send_idle_pct = 0;
      recv_idle_pct = 0;
      apply_settings(15'h0000, 15'h7FFF, 15'd4000, 15'd2000, 15'd2000, 15'd2000, 15'd2000);
      run_random(300);
      drain();

      // Random settings, with upper bits of narrow registers randomized
      apply_settings(15'($urandom_range(32767)),
                     {7'($urandom_range(127)), 8'($urandom_range(255, 10))},
                     {3'($urandom_range(7)), 12'($urandom_range(1500))},
                     {4'($urandom_range(15)), 11'($urandom_range(2000))},
                     {4'($urandom_range(15)), 11'($urandom_range(2000))},
                     {4'($urandom_range(15)), 11'($urandom_range(400))},
                     {4'($urandom_range(15)), 11'($urandom_range(200))});
      // receiver stops for a while as requests keep coming
      rsp_hold_off = 1'b1;
      run_random(300);
      // sender waits until all results are back
      drain();
      run_random(300);
      drain();

      $display("ran %0d poll ticks over four register settings, %0d results checked",
               ticks_sent, results_seen);
      $display("%0d results carried long presses, %0d arrow repeats; output stall exercised",
               long_seen, repeat_seen);
      if (mismatches == 0) begin
         $display("key_event_engine_unit_test passed");
      end else begin
         $display("key_event_engine_unit_test failed");
      end
      $finish;
   end

endmodule
